// ===== rtl/lec_pkg.sv =====
`timescale 1ns / 1ps
// Package: event codes, effect modes, register indexes and reset values of the LED effect controller.
package lec_pkg;

    // Event codes carried in the action field
    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_SET_ENABLE = 3'd1,
        ACT_TOGGLE     = 3'd2,
        ACT_SET_LEVEL  = 3'd3,
        ACT_UP         = 3'd4,
        ACT_DOWN       = 3'd5,
        ACT_SET_MODE   = 3'd6,
        ACT_NEXT_MODE  = 3'd7
    } action_t;

    // Effect modes
    localparam logic [1:0] MODE_FIXED  = 2'd0;
    localparam logic [1:0] MODE_BREATH = 2'd1;
    localparam logic [1:0] MODE_BLINK  = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_PERIOD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BREATH_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BREATH_INC    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_USER_INC      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_CEILING = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_FLOOR   = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_BLINK_PERIOD  = 16'd500;
    localparam logic [15:0] RST_BREATH_PERIOD = 16'd20;
    localparam logic [6:0]  RST_BREATH_INC    = 7'd4;
    localparam logic [7:0]  RST_USER_INC      = 8'd16;
    localparam logic [7:0]  RST_LEVEL_CEILING = 8'd255;
    localparam logic [7:0]  RST_LEVEL_FLOOR   = 8'd0;

    // State reset values
    localparam logic [7:0]  RST_BRIGHTNESS    = 8'd128;

endpackage

// ===== rtl/lec_if.sv =====
`timescale 1ns / 1ps
// Interfaces: event input, frame result and configuration write channels.

interface lec_event_if;
    import lec_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] now_ms;
    logic [7:0]  operand;

    modport source (output valid, output action, output now_ms, output operand, input ready);
    modport sink   (input valid, input action, input now_ms, input operand, output ready);
endinterface

interface lec_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_level;
    logic [7:0] current_brightness;
    logic [1:0] current_mode;
    logic       is_enabled;

    modport source (output valid, output frame_level, output current_brightness,
                    output current_mode, output is_enabled, input ready);
    modport sink   (input valid, input frame_level, input current_brightness,
                    input current_mode, input is_enabled, output ready);
endinterface

interface lec_cfg_if;
    import lec_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/led_effect_controller_core.sv =====
`timescale 1ns / 1ps
// Top level: LED effect controller, an event per cycle unless stalled, a frame per refresh.
//
//  channel  modport  moves                                     transfer when
//  evt      sink     action, now_ms, operand                   evt.valid && evt.ready
//  frame    source   frame_level, current_brightness,          frame.valid && frame.ready
//                    current_mode, is_enabled
//  cfg      sink     index, data                               cfg.valid (ready tied high)
//
//  An event sits in the input register while the single pass of update logic runs; the
//  edge on which it advances writes the state and the frame register together, so its
//  frame is offered from the frame register, which follows the input register.
//  One event is taken per cycle unless the frame side stalls, a rate set by the update pass.
//  The input register advances only while the frame register is free or being drained.
//  rst_n clears control state and loads the register and state defaults asynchronously.
module led_effect_controller_core
    import lec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lec_event_if.sink   evt,
    lec_frame_if.source frame,
    lec_cfg_if.sink     cfg
);

    // Configuration registers
    logic [15:0] blink_period_reg;
    logic [15:0] breath_period_reg;
    logic [6:0]  breath_inc_reg;
    logic [7:0]  user_inc_reg;
    logic [7:0]  ceiling_reg;
    logic [7:0]  floor_reg;

    // Effect state
    logic        enable_reg,     enable_next;
    logic [7:0]  bright_reg,     bright_next;
    logic [1:0]  mode_reg,       mode_next;
    logic [31:0] last_time_reg,  last_time_next;
    logic        falling_reg,    falling_next;
    logic        shown_reg,      shown_next;

    // Input register
    logic        in_valid_reg;
    action_t     act_reg;
    logic [31:0] now_reg;
    logic [7:0]  opnd_reg;

    // Frame register
    logic        out_valid_reg;
    logic [7:0]  out_level_reg;
    logic [7:0]  out_bright_reg;
    logic [1:0]  out_mode_reg;
    logic        out_enable_reg;

    logic        advance;
    logic        emit;
    logic [7:0]  level;
    logic        evt_xfer;

    logic [31:0]       elapsed;
    logic              blink_due;
    logic              breath_due;
    logic signed [9:0] ramp_sum;
    logic              ramp_hi;
    logic              ramp_lo;
    logic [8:0]        up_sum;
    logic [7:0]        up_level;
    logic [7:0]        down_level;

    assign cfg.ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period_reg  <= RST_BLINK_PERIOD;
            breath_period_reg <= RST_BREATH_PERIOD;
            breath_inc_reg    <= RST_BREATH_INC;
            user_inc_reg      <= RST_USER_INC;
            ceiling_reg       <= RST_LEVEL_CEILING;
            floor_reg         <= RST_LEVEL_FLOOR;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BLINK_PERIOD:  blink_period_reg  <= cfg.data;
                CFG_BREATH_PERIOD: breath_period_reg <= cfg.data;
                CFG_BREATH_INC:    breath_inc_reg    <= cfg.data[6:0];
                CFG_USER_INC:      user_inc_reg      <= cfg.data[7:0];
                CFG_LEVEL_CEILING: ceiling_reg       <= cfg.data[7:0];
                CFG_LEVEL_FLOOR:   floor_reg         <= cfg.data[7:0];
                default:           ;
            endcase
        end
    end

    // Handshake: advance when the frame register can take a new frame
    assign advance   = in_valid_reg && (!out_valid_reg || frame.ready);
    assign evt.ready = !in_valid_reg || advance;
    assign evt_xfer  = evt.valid && evt.ready;

    // Hold the accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_xfer)
        begin
            act_reg  <= action_t'(evt.action);
            now_reg  <= evt.now_ms;
            opnd_reg <= evt.operand;
        end
    end

    // Timing and level arithmetic
    assign elapsed    = now_reg - last_time_reg;
    assign blink_due  = elapsed >= {16'd0, blink_period_reg};
    assign breath_due = elapsed >= {16'd0, breath_period_reg};
    assign ramp_sum   = falling_reg
                        ? ($signed({2'b00, bright_reg}) - $signed({3'b000, breath_inc_reg}))
                        : ($signed({2'b00, bright_reg}) + $signed({3'b000, breath_inc_reg}));
    assign ramp_hi    = ramp_sum >= $signed({2'b00, ceiling_reg});
    assign ramp_lo    = ramp_sum <= $signed({2'b00, user_inc_reg});
    assign up_sum     = {1'b0, bright_reg} + {1'b0, user_inc_reg};
    assign up_level   = (up_sum > {1'b0, ceiling_reg}) ? ceiling_reg : up_sum[7:0];
    assign down_level = (bright_reg <= user_inc_reg) ? floor_reg : (bright_reg - user_inc_reg);

    // Decode the event against the current state
    always_comb
    begin
        enable_next    = enable_reg;
        bright_next    = bright_reg;
        mode_next      = mode_reg;
        last_time_next = last_time_reg;
        falling_next   = falling_reg;
        shown_next     = shown_reg;
        emit           = 1'b1;
        level          = bright_reg;
        case (act_reg)
            ACT_TICK:
            begin
                emit = 1'b0;
                if (enable_reg && mode_reg == MODE_BLINK && blink_due)
                begin
                    emit           = 1'b1;
                    last_time_next = now_reg;
                    shown_next     = !shown_reg;
                    level          = shown_reg ? 8'd0 : bright_reg;
                end
                else if (enable_reg && mode_reg == MODE_BREATH && breath_due)
                begin
                    emit           = 1'b1;
                    last_time_next = now_reg;
                    if (ramp_hi)
                    begin
                        bright_next  = ceiling_reg;
                        falling_next = 1'b1;
                    end
                    else if (ramp_lo)
                    begin
                        bright_next  = user_inc_reg;
                        falling_next = 1'b0;
                    end
                    else
                    begin
                        bright_next = ramp_sum[7:0];
                    end
                    level = bright_next;
                end
            end
            ACT_SET_ENABLE:
            begin
                enable_next = (opnd_reg != 8'd0);
                shown_next  = 1'b1;
            end
            ACT_TOGGLE:
            begin
                enable_next = !enable_reg;
                shown_next  = 1'b1;
            end
            ACT_SET_LEVEL:
            begin
                bright_next = opnd_reg;
                level       = opnd_reg;
            end
            ACT_UP:
            begin
                bright_next = up_level;
                level       = up_level;
            end
            ACT_DOWN:
            begin
                bright_next = down_level;
                level       = down_level;
            end
            ACT_SET_MODE:
            begin
                mode_next      = (opnd_reg > {6'd0, MODE_BLINK}) ? MODE_FIXED : opnd_reg[1:0];
                last_time_next = now_reg;
                falling_next   = 1'b0;
                shown_next     = 1'b1;
            end
            ACT_NEXT_MODE:
            begin
                mode_next      = (mode_reg == MODE_BLINK) ? MODE_FIXED : (mode_reg + 2'd1);
                last_time_next = now_reg;
                falling_next   = 1'b0;
                shown_next     = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Commit the state on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            bright_reg    <= RST_BRIGHTNESS;
            mode_reg      <= MODE_FIXED;
            last_time_reg <= 32'd0;
            falling_reg   <= 1'b0;
            shown_reg     <= 1'b1;
        end
        else if (advance)
        begin
            enable_reg    <= enable_next;
            bright_reg    <= bright_next;
            mode_reg      <= mode_next;
            last_time_reg <= last_time_next;
            falling_reg   <= falling_next;
            shown_reg     <= shown_next;
        end
    end

    // Load or drop the frame register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_level_reg  <= enable_next ? level : 8'd0;
            out_bright_reg <= bright_next;
            out_mode_reg   <= mode_next;
            out_enable_reg <= enable_next;
        end
    end

    assign frame.valid              = out_valid_reg;
    assign frame.frame_level        = out_level_reg;
    assign frame.current_brightness = out_bright_reg;
    assign frame.current_mode       = out_mode_reg;
    assign frame.is_enabled         = out_enable_reg;

`ifndef NO_ASSERTIONS
    // A disabled strip never shows light
    a_dark_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && !frame.is_enabled |-> frame.frame_level == 8'd0)
        else $error("frame level nonzero while disabled");

    // A refresh lands in the frame register the cycle after it advances
    a_emit_loads_frame: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> frame.valid)
        else $error("refresh lost on its way to the frame register");

    // A tick while disabled refreshes nothing
    a_no_tick_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && act_reg == ACT_TICK && !enable_reg |-> !emit)
        else $error("tick refreshed a disabled strip");

    // The mode register never holds the unused code
    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'd3)
        else $error("effect mode out of range");

    // An empty input register always takes an event
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> evt.ready)
        else $error("input stalled while empty");
`endif

endmodule

// ===== tb/led_effect_controller_core_test.sv =====
`timescale 1ns / 1ps
// Testbench: drives events into the LED effect controller and checks every frame against a predictor.
module led_effect_controller_core_test;
    import lec_pkg::*;

    localparam int CLK_PERIOD_NS = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASE_EVENTS  = 215;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef struct packed {
        logic [7:0] frame_level;
        logic [7:0] brightness;
        logic [1:0] mode;
        logic       enabled;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n;

    lec_event_if evt_bus ();
    lec_frame_if frame_bus ();
    lec_cfg_if   cfg_bus ();

    led_effect_controller_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_bus),
        .frame (frame_bus),
        .cfg   (cfg_bus)
    );

    // Register copies held by the predictor
    logic [15:0] cfg_blink_ms    = RST_BLINK_PERIOD;
    logic [15:0] cfg_breath_ms   = RST_BREATH_PERIOD;
    logic [6:0]  cfg_breath_step = RST_BREATH_INC;
    logic [7:0]  cfg_user_step   = RST_USER_INC;
    logic [7:0]  cfg_ceiling     = RST_LEVEL_CEILING;
    logic [7:0]  cfg_floor       = RST_LEVEL_FLOOR;

    // Controller state held by the predictor
    logic        led_enabled  = 1'b0;
    logic [7:0]  led_level    = RST_BRIGHTNESS;
    logic [1:0]  led_mode     = MODE_FIXED;
    logic [31:0] last_step_ms = 32'd0;
    logic        ramp_down    = 1'b0;
    logic        blink_lit    = 1'b1;

    frame_t      pending_frames[$];
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles   = 0;
    logic [31:0] ms_cursor     = 32'd0;

    always #(CLK_PERIOD_NS / 2) clk = ~clk;

    // Switch to a new effect: restart timing, ramp up, show the strip
    function automatic void enter_mode(input logic [1:0] mode_sel, input logic [31:0] now);
        led_mode     = mode_sel;
        last_step_ms = now;
        ramp_down    = 1'b0;
        blink_lit    = 1'b1;
    endfunction

    // Advance the controller state by one event; return 1 when it refreshes the strip
    function automatic bit apply_event(input action_t act, input logic [31:0] now,
                                       input logic [7:0] opnd, output frame_t frame_out);
        logic [31:0] elapsed;
        int          ramp;
        int          sum;
        int          shown_level;
        bit          refresh;
        elapsed = now - last_step_ms;
        refresh = 1'b1;
        shown_level = 0;
        case (act)
            ACT_TICK:
            begin
                refresh = 1'b0;
                if (led_enabled && led_mode == MODE_BLINK && elapsed >= 32'(cfg_blink_ms))
                begin
                    last_step_ms = now;
                    blink_lit    = !blink_lit;
                    refresh      = 1'b1;
                end
                else if (led_enabled && led_mode == MODE_BREATH
                         && elapsed >= 32'(cfg_breath_ms))
                begin
                    ramp = ramp_down ? int'(led_level) - int'(cfg_breath_step)
                                     : int'(led_level) + int'(cfg_breath_step);
                    last_step_ms = now;
                    if (ramp >= int'(cfg_ceiling))
                    begin
                        ramp      = int'(cfg_ceiling);
                        ramp_down = 1'b1;
                    end
                    else if (ramp <= int'(cfg_user_step))
                    begin
                        ramp      = int'(cfg_user_step);
                        ramp_down = 1'b0;
                    end
                    led_level = 8'(ramp);
                    refresh   = 1'b1;
                end
            end
            ACT_SET_ENABLE:
            begin
                led_enabled = (opnd != 8'd0);
                blink_lit   = 1'b1;
            end
            ACT_TOGGLE:
            begin
                led_enabled = !led_enabled;
                blink_lit   = 1'b1;
            end
            ACT_SET_LEVEL:
                led_level = opnd;
            ACT_UP:
            begin
                sum = int'(led_level) + int'(cfg_user_step);
                led_level = (sum > int'(cfg_ceiling)) ? cfg_ceiling : 8'(sum);
            end
            ACT_DOWN:
                led_level = (led_level <= cfg_user_step) ? cfg_floor : led_level - cfg_user_step;
            ACT_SET_MODE:
                enter_mode((opnd > 8'(MODE_BLINK)) ? MODE_FIXED : opnd[1:0], now);
            default:
                enter_mode((led_mode == MODE_BLINK) ? MODE_FIXED : led_mode + 2'd1, now);
        endcase
        // Blink ticks show the lit or dark phase; every other refresh shows the level
        if (act == ACT_TICK && led_mode == MODE_BLINK)
            shown_level = blink_lit ? int'(led_level) : 0;
        else
            shown_level = int'(led_level);
        frame_out.frame_level = led_enabled ? 8'(shown_level) : 8'd0;
        frame_out.brightness  = led_level;
        frame_out.mode        = led_mode;
        frame_out.enabled     = led_enabled;
        return refresh;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Offer one event, hold it until the transfer, then predict its frame
    task automatic send_event(input action_t act, input logic [31:0] now,
                              input logic [7:0] opnd);
        frame_t next_frame;
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_bus.valid <= 1'b0;
            @(posedge clk);
        end
        evt_bus.valid   <= 1'b1;
        evt_bus.action  <= act;
        evt_bus.now_ms  <= now;
        evt_bus.operand <= opnd;
        @(posedge clk);
        while (evt_bus.ready !== 1'b1)
            @(posedge clk);
        if (apply_event(act, now, opnd, next_frame))
            pending_frames.push_back(next_frame);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_BLINK_PERIOD:  cfg_blink_ms    = 16'(value);
            CFG_BREATH_PERIOD: cfg_breath_ms   = 16'(value);
            CFG_BREATH_INC:    cfg_breath_step = 7'(value);
            CFG_USER_INC:      cfg_user_step   = 8'(value);
            CFG_LEVEL_CEILING: cfg_ceiling     = 8'(value);
            CFG_LEVEL_FLOOR:   cfg_floor       = 8'(value);
            default: ;
        endcase
    endtask

    // Write all six registers back to back, then drop the write valid
    task automatic load_settings(input int blink_ms, input int breath_ms, input int breath_step,
                                 input int user_step, input int ceiling, input int level_floor);
        write_reg(CFG_BLINK_PERIOD, blink_ms);
        write_reg(CFG_BREATH_PERIOD, breath_ms);
        write_reg(CFG_BREATH_INC, breath_step);
        write_reg(CFG_USER_INC, user_step);
        write_reg(CFG_LEVEL_CEILING, ceiling);
        write_reg(CFG_LEVEL_FLOOR, level_floor);
        cfg_bus.valid <= 1'b0;
    endtask

    // Stop offering events, wait for every expected frame, then let the pipeline settle
    task automatic wait_idle();
        int     waited;
        frame_t lost;
        evt_bus.valid <= 1'b0;
        waited = 0;
        while (pending_frames.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (pending_frames.size() != 0)
        begin
            lost = pending_frames.pop_front();
            $display("%0t ns: frame expected (level %0d, brightness %0d), got none",
                     $time, lost.frame_level, lost.brightness);
            error_count++;
        end
    endtask

    // Mostly ticks that walk time forward across the effect periods, plus user actions
    task automatic send_random_event();
        int          pick;
        int          span;
        logic [7:0]  opnd;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            span = (led_mode == MODE_BLINK) ? int'(cfg_blink_ms) : int'(cfg_breath_ms);
            if ($urandom_range(19) == 0)
                ms_cursor = ms_cursor + $urandom;
            else
                ms_cursor = ms_cursor + 32'($urandom_range(0, span + 2));
            send_event(ACT_TICK, ms_cursor, 8'($urandom));
        end
        else if (pick < 56)
        begin
            opnd = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            send_event(ACT_SET_ENABLE, ms_cursor, opnd);
        end
        else if (pick < 59)
            send_event(ACT_TOGGLE, ms_cursor, 8'($urandom));
        else if (pick < 66)
            send_event(ACT_SET_LEVEL, ms_cursor, 8'($urandom));
        else if (pick < 73)
            send_event(ACT_UP, ms_cursor, 8'($urandom));
        else if (pick < 80)
            send_event(ACT_DOWN, ms_cursor, 8'($urandom));
        else if (pick < 88)
        begin
            span = $urandom_range(99);
            if (span < 60)
                opnd = 8'($urandom_range(MODE_BREATH, MODE_BLINK));
            else if (span < 85)
                opnd = 8'(MODE_FIXED);
            else
                opnd = 8'($urandom_range(3, 255));
            send_event(ACT_SET_MODE, ms_cursor, opnd);
        end
        else if (pick < 93)
            send_event(ACT_NEXT_MODE, ms_cursor, 8'($urandom));
        else
            send_event(action_t'($urandom_range(7)), $urandom, 8'($urandom));
    endtask

    task automatic run_random_events(input int count);
        for (int i = 0; i < count; i++)
            send_random_event();
    endtask

    task automatic test_directed_events();
        send_event(ACT_TICK, 32'd0, 8'd0);                 // disabled: no refresh
        send_event(ACT_SET_LEVEL, 32'd1, 8'd0);            // disabled: frame forced dark
        send_event(ACT_SET_ENABLE, 32'd2, 8'h80);          // any nonzero operand enables
        send_event(ACT_UP, 32'd3, 8'd0);
        send_event(ACT_SET_LEVEL, 32'd4, 8'hFF);
        send_event(ACT_UP, 32'd5, 8'hFF);                  // saturate at the ceiling
        send_event(ACT_SET_LEVEL, 32'd6, 8'd16);
        send_event(ACT_DOWN, 32'd7, 8'd0);                 // at the step: drop to the floor
        send_event(ACT_SET_MODE, 32'd1000, 8'(MODE_BREATH));
        send_event(ACT_TICK, 32'd1019, 8'd0);              // period not yet elapsed
        send_event(ACT_TICK, 32'd1020, 8'd0);              // clamp up to the breath floor
        send_event(ACT_SET_LEVEL, 32'd1030, 8'd253);
        send_event(ACT_TICK, 32'd1040, 8'd0);              // clamp to the ceiling, turn down
        send_event(ACT_TICK, 32'd1060, 8'd0);
        send_event(ACT_SET_MODE, 32'hFFFF_FF00, 8'(MODE_BLINK));
        send_event(ACT_TICK, 32'h0000_00F3, 8'd0);         // wrapped, one short of the period
        send_event(ACT_TICK, 32'h0000_00F4, 8'd0);         // wrapped: go dark
        send_event(ACT_UP, 32'h0000_0100, 8'd0);           // level shown while dark
        send_event(ACT_TICK, 32'h0000_02E8, 8'd0);         // lit again
        send_event(ACT_SET_MODE, 32'd800, 8'hFF);          // out-of-range mode means fixed
        send_event(ACT_TICK, 32'd5000, 8'd0);              // fixed mode: no refresh
        send_event(ACT_NEXT_MODE, 32'd5001, 8'd0);
        send_event(ACT_NEXT_MODE, 32'd5002, 8'd0);
        send_event(ACT_NEXT_MODE, 32'd5003, 8'd0);         // blink wraps back to fixed
        send_event(ACT_TOGGLE, 32'd5004, 8'd0);
        send_event(ACT_SET_ENABLE, 32'd5005, 8'd0);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        load_settings(1, 1, 1, 1, 255, 0);
        run_random_events(PHASE_EVENTS);
        wait_idle();
        load_settings(65535, 65535, 64, 128, 1, 255);
        run_random_events(PHASE_EVENTS);
        wait_idle();
        // zero periods: every tick steps the effect
        load_settings(0, 0, 64, 128, 255, 255);
        run_random_events(PHASE_EVENTS);
        wait_idle();
        load_settings(37, 9, 7, 40, 200, 3);
        run_random_events(PHASE_EVENTS);
        wait_idle();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 3; phase++)
        begin
            load_settings($urandom_range(1, 300), $urandom_range(1, 50), $urandom_range(1, 64),
                          $urandom_range(1, 128), $urandom_range(1, 255),
                          $urandom_range(0, 255));
            run_random_events(PHASE_EVENTS);
            wait_idle();
        end
    endtask

    // Hold the frame side off while refreshes keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_cycles = 150;
        send_event(ACT_SET_ENABLE, ms_cursor, 8'd1);
        for (int i = 0; i < 60; i++)
            send_event(($urandom_range(1) != 0) ? ACT_UP : ACT_DOWN, ms_cursor, 8'($urandom));
        wait_idle();
    endtask

    task automatic test_default_timing();
        load_settings(RST_BLINK_PERIOD, RST_BREATH_PERIOD, RST_BREATH_INC, RST_USER_INC,
                      RST_LEVEL_CEILING, RST_LEVEL_FLOOR);
        run_random_events(PHASE_EVENTS);
        wait_idle();
    endtask

    // Frame side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        frame_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                frame_bus.ready <= 1'b0;
            end
            else
                frame_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each frame transfer with the oldest expected frame
    always @(posedge clk)
    begin
        frame_t want;
        if (frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t ns: frame expected none, got level %0d brightness %0d",
                         $time, frame_bus.frame_level, frame_bus.current_brightness);
                error_count++;
            end
            else
            begin
                want = pending_frames.pop_front();
                check_field("frame_level", want.frame_level, frame_bus.frame_level);
                check_field("current_brightness", want.brightness,
                            frame_bus.current_brightness);
                check_field("current_mode", want.mode, frame_bus.current_mode);
                check_field("is_enabled", want.enabled, frame_bus.is_enabled);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("led_effect_controller_core_test: errors");
        $finish;
    end

    initial
    begin
        rst_n           <= 1'b0;
        evt_bus.valid   <= 1'b0;
        evt_bus.action  <= ACT_TICK;
        evt_bus.now_ms  <= 32'd0;
        evt_bus.operand <= 8'd0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.index   <= CFG_BLINK_PERIOD;
        cfg_bus.data    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 34;
        recv_idle_pct = 61;
        test_directed_events();
        test_register_extremes();
        send_idle_pct = 61;
        recv_idle_pct = 34;
        test_random_settings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_default_timing();

        if (error_count == 0)
            $display("led_effect_controller_core_test: clean");
        else
            $display("led_effect_controller_core_test: errors");
        $finish;
    end

endmodule

// ===== led_effect_controller_core.f =====
rtl/lec_pkg.sv
rtl/lec_if.sv
rtl/led_effect_controller_core.sv
tb/led_effect_controller_core_test.sv
